>>> sv/gbn_pkg.sv
package gbn_pkg;

	// default sizes
	localparam int MAX_KEPT_DEF  = 64;
	localparam int MAX_BOXES_DEF = 8192;

	// overlap threshold, 1/256 units; reset value is one half
	localparam int          THR_W     = 9;
	localparam logic [8:0]  THR_RESET = 9'd128;

	localparam int POS_OUT_W = 13;

	// operand widths of the shared multiplier
	localparam int MUL_A_W = 31;
	localparam int MUL_B_W = 15;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// one stored box
	typedef struct packed {
		logic [14:0] height;
		logic [14:0] width;
		logic [15:0] top;
		logic [15:0] left;
	} box_t;

	localparam int BOX_W = $bits(box_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAREA,
		ST_READ,
		ST_OVL,
		ST_MINT,
		ST_MAREA,
		ST_UNION,
		ST_MTHR,
		ST_CMP,
		ST_DONE
	} state_t;

	// multiplier operand select
	typedef enum logic [1:0] {
		MSEL_CAND,
		MSEL_INTER,
		MSEL_OTHER,
		MSEL_THR
	} mul_sel_t;

endpackage

>>> sv/gbn_ram.sv
module gbn_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/greedy_box_nms.sv
// Channel   | Direction | Handshake          | Word
// ----------+-----------+--------------------+----------------------------------------------
// input     | in        | in_valid/in_stall  | box_left box_top box_width box_height set_end
// output    | out       | out_valid/out_stall| kept box_position store_overflow final_box
// config    | in        | cfg_we             | cfg_data (iou_threshold)
//
// Scan: each taken box is compared against the n boxes held in the store (up to
//   MAX_KEPT) in store order, and the scan stops at the first suppressing box.
//   A compare runs the store read, the overlap step, the intersection and stored
//   box area products, the union step, the threshold product and the compare;
//   the one shared multiplier is used three times per compare. The next box can
//   be taken as soon as the result word of the one before it is registered.
// Reset: arst_n clears the counts, the sequencer and the output valid; the
//   threshold goes to one half. The store itself is not cleared.
// Stalls: in_stall is high from the taking of a box until its result is registered.
//   A finished word waits in the output register; a new box is taken meanwhile,
//   and the sequencer holds its result until the output register frees up.
module greedy_box_nms #(
	parameter int MAX_KEPT  = gbn_pkg::MAX_KEPT_DEF,
	parameter int MAX_BOXES = gbn_pkg::MAX_BOXES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,

	input  logic                      cfg_we,
	input  logic [gbn_pkg::THR_W-1:0] cfg_data,

	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [15:0]               box_left,
	input  logic [15:0]               box_top,
	input  logic [14:0]               box_width,
	input  logic [14:0]               box_height,
	input  logic                      set_end,

	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kept,
	output logic [12:0]               box_position,
	output logic                      store_overflow,
	output logic                      final_box
);

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;   // store address
	localparam int CW = $clog2(MAX_KEPT + 1);                    // kept count
	localparam int PW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1; // position

	// ---------------- state ----------------
	gbn_pkg::state_t state_q, state_d;

	logic [gbn_pkg::THR_W-1:0] thr_q;
	logic [CW-1:0]             cnt_q;   // boxes in the store
	logic [CW-1:0]             idx_q;   // scan index
	logic [PW-1:0]             pos_q;   // position of the box being worked on

	// candidate box, edges sign extended to 17 bits
	logic [16:0]         cx0_q, cy0_q, cx1_q, cy1_q;
	gbn_pkg::box_t       cbox_q;
	logic                last_q;
	logic                keep_q;

	// compare datapath
	logic [29:0]         carea_q;
	logic [14:0]         dx_q, dy_q, ow_q, oh_q;
	logic [29:0]         inter_q;
	logic [29:0]         oarea_q;
	logic [30:0]         union_q;
	logic [39:0]         thrprod_q;

	// output register
	logic                out_valid_q;
	logic                kept_q, ovf_q, final_q;
	logic [12:0]         pos_out_q;

	// ---------------- store ----------------
	gbn_pkg::box_t  rd_box;
	logic           st_we;
	logic [AW-1:0]  st_waddr, st_raddr;

	gbn_ram #(
		.WIDTH (gbn_pkg::BOX_W),
		.DEPTH (MAX_KEPT)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (cbox_q),
		.raddr (st_raddr),
		.rdata (rd_box)
	);

	assign st_waddr = cnt_q[AW-1:0];
	assign st_raddr = idx_q[AW-1:0];

	// ---------------- handshakes ----------------
	logic in_fire, out_free, room, done_fire;

	assign in_stall  = (state_q != gbn_pkg::ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign room      = (cnt_q < CW'(MAX_KEPT));
	assign done_fire = (state_q == gbn_pkg::ST_DONE) && out_free;

	// ---------------- shared multiplier ----------------
	gbn_pkg::mul_sel_t                mul_sel;
	logic [gbn_pkg::MUL_A_W-1:0]      mul_a;
	logic [gbn_pkg::MUL_B_W-1:0]      mul_b;
	logic [gbn_pkg::MUL_P_W-1:0]      mul_p;

	always_comb begin
		case (mul_sel)
			gbn_pkg::MSEL_CAND: begin
				mul_a = {16'd0, cbox_q.width};
				mul_b = cbox_q.height;
			end
			gbn_pkg::MSEL_INTER: begin
				mul_a = {16'd0, dx_q};
				mul_b = dy_q;
			end
			gbn_pkg::MSEL_OTHER: begin
				mul_a = {16'd0, ow_q};
				mul_b = oh_q;
			end
			default: begin
				mul_a = union_q;
				mul_b = {6'd0, thr_q};
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ---------------- overlap of candidate and stored box ----------------
	logic [16:0] ox0, oy0, ox1, oy1;
	logic [16:0] lx, ly, hx, hy;
	logic [17:0] dx, dy;
	logic        dx_pos, dy_pos;

	always_comb begin
		ox0 = {rd_box.left[15], rd_box.left};
		oy0 = {rd_box.top[15], rd_box.top};
		ox1 = ox0 + {2'b00, rd_box.width};
		oy1 = oy0 + {2'b00, rd_box.height};
		lx  = ($signed(cx0_q) > $signed(ox0)) ? cx0_q : ox0;
		ly  = ($signed(cy0_q) > $signed(oy0)) ? cy0_q : oy0;
		hx  = ($signed(cx1_q) < $signed(ox1)) ? cx1_q : ox1;
		hy  = ($signed(cy1_q) < $signed(oy1)) ? cy1_q : oy1;
		dx  = {hx[16], hx} - {lx[16], lx};
		dy  = {hy[16], hy} - {ly[16], ly};
		// touching or apart gives no overlap
		dx_pos = !dx[17] && (dx != 18'd0);
		dy_pos = !dy[17] && (dy != 18'd0);
	end

	// inter*256 against threshold*union, full 40 bit compare
	logic suppress;
	assign suppress = ({2'b00, inter_q, 8'd0} > thrprod_q);

	// ---------------- sequencer: next state ----------------
	logic [CW-1:0] idx_nxt;
	assign idx_nxt = idx_q + CW'(1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbn_pkg::ST_IDLE:  if (in_fire) state_d = gbn_pkg::ST_CAREA;
			gbn_pkg::ST_CAREA: state_d = (cnt_q == '0) ? gbn_pkg::ST_DONE : gbn_pkg::ST_READ;
			gbn_pkg::ST_READ:  state_d = gbn_pkg::ST_OVL;
			gbn_pkg::ST_OVL:   state_d = gbn_pkg::ST_MINT;
			gbn_pkg::ST_MINT:  state_d = gbn_pkg::ST_MAREA;
			gbn_pkg::ST_MAREA: state_d = gbn_pkg::ST_UNION;
			gbn_pkg::ST_UNION: state_d = gbn_pkg::ST_MTHR;
			gbn_pkg::ST_MTHR:  state_d = gbn_pkg::ST_CMP;
			gbn_pkg::ST_CMP: begin
				if (suppress || idx_nxt == cnt_q) begin
					state_d = gbn_pkg::ST_DONE;
				end else begin
					state_d = gbn_pkg::ST_READ;
				end
			end
			gbn_pkg::ST_DONE:  if (out_free) state_d = gbn_pkg::ST_IDLE;
			default:           state_d = gbn_pkg::ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	always_comb begin
		mul_sel = gbn_pkg::MSEL_THR;
		st_we   = 1'b0;
		unique case (state_q)
			gbn_pkg::ST_CAREA: mul_sel = gbn_pkg::MSEL_CAND;
			gbn_pkg::ST_MINT:  mul_sel = gbn_pkg::MSEL_INTER;
			gbn_pkg::ST_MAREA: mul_sel = gbn_pkg::MSEL_OTHER;
			gbn_pkg::ST_DONE:  st_we   = out_free && keep_q && room;
			default:           mul_sel = gbn_pkg::MSEL_THR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- control registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= gbn_pkg::THR_RESET;
			cnt_q  <= '0;
			idx_q  <= '0;
			pos_q  <= '0;
			keep_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				thr_q <= cfg_data;
			end
			if (in_fire) begin
				idx_q  <= '0;
				keep_q <= 1'b1;
			end
			if (state_q == gbn_pkg::ST_CMP) begin
				idx_q <= idx_nxt;
				if (suppress) begin
					keep_q <= 1'b0;
				end
			end
			if (done_fire) begin
				if (last_q) begin
					cnt_q <= '0;
					pos_q <= '0;
				end else begin
					if (keep_q && room) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (pos_q < PW'(MAX_BOXES - 1)) begin
						pos_q <= pos_q + PW'(1);
					end
				end
			end
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cbox_q <= '{height: box_height, width: box_width, top: box_top, left: box_left};
			cx0_q  <= {box_left[15], box_left};
			cy0_q  <= {box_top[15], box_top};
			cx1_q  <= {box_left[15], box_left} + {2'b00, box_width};
			cy1_q  <= {box_top[15], box_top} + {2'b00, box_height};
			last_q <= set_end;
		end
		case (state_q)
			gbn_pkg::ST_CAREA: carea_q <= mul_p[29:0];
			gbn_pkg::ST_OVL: begin
				dx_q <= dx_pos ? dx[14:0] : 15'd0;
				dy_q <= dy_pos ? dy[14:0] : 15'd0;
				ow_q <= rd_box.width;
				oh_q <= rd_box.height;
			end
			gbn_pkg::ST_MINT:  inter_q   <= mul_p[29:0];
			gbn_pkg::ST_MAREA: oarea_q   <= mul_p[29:0];
			gbn_pkg::ST_UNION: union_q   <= {1'b0, carea_q} + {1'b0, oarea_q} - {1'b0, inter_q};
			gbn_pkg::ST_MTHR:  thrprod_q <= mul_p[39:0];
			default: ;
		endcase
	end

	// ---------------- output register ----------------
	logic [12:0] pos_ext;

	generate
		if (PW >= gbn_pkg::POS_OUT_W) begin : g_pos_cut
			assign pos_ext = pos_q[12:0];
		end else begin : g_pos_ext
			assign pos_ext = {{(gbn_pkg::POS_OUT_W - PW){1'b0}}, pos_q};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			kept_q    <= keep_q;
			ovf_q     <= keep_q && !room;
			final_q   <= last_q;
			pos_out_q <= pos_ext;
		end
	end

	assign out_valid      = out_valid_q;
	assign kept           = kept_q;
	assign store_overflow = ovf_q;
	assign final_box      = final_q;
	assign box_position   = pos_out_q;

`ifndef SYNTHESIS
	// store never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_KEPT))
		else $error("kept count beyond store depth");

	// scan never runs past the filled part of the store
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbn_pkg::ST_READ) |-> (idx_q < cnt_q))
		else $error("scan index past kept count");

	// an overflow word always reports the box kept
	a_ovf_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kept || !store_overflow))
		else $error("overflow on a suppressed box");

	// a store write grows the count unless the set closes
	a_write_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we && !last_q) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("store write without count step");
`endif

endmodule

>>> sim/greedy_box_nms_tb.sv
`timescale 1ns / 1ps

module greedy_box_nms_tb;

	localparam int MAX_KEPT  = gbn_pkg::MAX_KEPT_DEF;
	localparam int MAX_BOXES = gbn_pkg::MAX_BOXES_DEF;

	// one result word as the block reports it
	typedef struct packed {
		logic        keep;
		logic [12:0] pos;
		logic        ovf;
		logic        last;
	} verdict_t;

	// directed stimulus row; a typed row carries its expected word
	typedef struct {
		gbn_pkg::box_t box;
		logic          last;
		logic          typed;
		verdict_t      want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      cfg_we = 1'b0;
	logic [gbn_pkg::THR_W-1:0] cfg_data = '0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] box_left = '0;
	logic [15:0] box_top = '0;
	logic [14:0] box_width = '0;
	logic [14:0] box_height = '0;
	logic        set_end = 1'b0;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kept;
	logic [12:0] box_position;
	logic        store_overflow;
	logic        final_box;

	// shadow of the block: kept-box store, counts and threshold
	gbn_pkg::box_t held_boxes [MAX_KEPT];
	int            held_n = 0;
	int            set_pos = 0;
	logic [8:0]    iou_thr = gbn_pkg::THR_RESET;

	verdict_t pending_verdicts [$];
	dir_row_t dir_rows [$];
	int       mismatch_cnt = 0;
	logic     quiet = 1'b0;	// when set, neither side idles

	greedy_box_nms u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.box_left      (box_left),
		.box_top       (box_top),
		.box_width     (box_width),
		.box_height    (box_height),
		.set_end       (set_end),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kept          (kept),
		.box_position  (box_position),
		.store_overflow(store_overflow),
		.final_box     (final_box)
	);

	always #4 clk = ~clk;

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $time, what);
		mismatch_cnt++;
	endtask

	// area is just width*height; both unsigned 15 bit
	function automatic longint box_area(input gbn_pkg::box_t b);
		return longint'(b.width) * longint'(b.height);
	endfunction

	// intersection area; touching or disjoint boxes give zero
	function automatic longint overlap_area(input gbn_pkg::box_t a, input gbn_pkg::box_t b);
		longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, lx, ly, hx, hy;
		ax0 = longint'($signed(a.left));
		ay0 = longint'($signed(a.top));
		ax1 = ax0 + longint'(a.width);
		ay1 = ay0 + longint'(a.height);
		bx0 = longint'($signed(b.left));
		by0 = longint'($signed(b.top));
		bx1 = bx0 + longint'(b.width);
		by1 = by0 + longint'(b.height);
		lx = ax0 > bx0 ? ax0 : bx0;
		ly = ay0 > by0 ? ay0 : by0;
		hx = ax1 < bx1 ? ax1 : bx1;
		hy = ay1 < by1 ? ay1 : by1;
		if (hx <= lx || hy <= ly)
			return 0;
		return (hx - lx) * (hy - ly);
	endfunction

	// greedy suppression of one box against the held set; updates the shadow
	function automatic verdict_t nms_decide(input gbn_pkg::box_t cand, input logic last);
		verdict_t v;
		logic     survive;
		longint   inter, uni;
		survive = 1'b1;
		for (int j = 0; j < held_n; j++) begin
			inter = overlap_area(cand, held_boxes[j]);
			uni   = box_area(cand) + box_area(held_boxes[j]) - inter;
			if (inter * 256 > longint'(iou_thr) * uni)
				survive = 1'b0;
		end
		v.keep = survive;
		v.ovf  = 1'b0;
		if (survive) begin
			if (held_n < MAX_KEPT) begin
				held_boxes[held_n] = cand;
				held_n++;
			end else begin
				v.ovf = 1'b1;	// full store: still kept, not held
			end
		end
		v.pos  = set_pos[12:0];
		v.last = last;
		if (set_pos < MAX_BOXES - 1)
			set_pos++;
		if (last) begin
			held_n  = 0;
			set_pos = 0;
		end
		return v;
	endfunction

	// jittered box around a cluster center, now and then with zero width
	function automatic gbn_pkg::box_t cluster_box(input int cx, input int cy, input int bw,
			input int bh);
		gbn_pkg::box_t b;
		int            w, h, jx, jy;
		w  = bw + int'($urandom_range(0, bw / 2)) - bw / 4;
		h  = bh + int'($urandom_range(0, bh / 2)) - bh / 4;
		jx = int'($urandom_range(0, bw / 2)) - bw / 4;
		jy = int'($urandom_range(0, bh / 2)) - bh / 4;
		if ($urandom_range(0, 19) == 0)
			w = 0;
		w = w > 32767 ? 32767 : w;
		h = h > 32767 ? 32767 : h;
		b.left   = 16'(cx - w / 2 + jx);
		b.top    = 16'(cy - h / 2 + jy);
		b.width  = 15'(w);
		b.height = 15'(h);
		return b;
	endfunction

	function automatic gbn_pkg::box_t make_box(input int l, input int t, input int w,
			input int h);
		gbn_pkg::box_t b;
		b.left   = 16'(l);
		b.top    = 16'(t);
		b.width  = 15'(w);
		b.height = 15'(h);
		return b;
	endfunction

	task automatic dir_row(input int l, input int t, input int w, input int h, input logic last,
			input logic typed, input logic k, input int p, input logic o);
		dir_row_t r;
		r.box   = make_box(l, t, w, h);
		r.last  = last;
		r.typed = typed;
		r.want  = '{keep: k, pos: 13'(p), ovf: o, last: last};
		dir_rows = {dir_rows, r};
	endtask

	// present one word, hold it through stalls, then predict its result
	task automatic send_box(input gbn_pkg::box_t b, input logic last, input logic typed,
			input verdict_t typed_v);
		verdict_t v;
		while (!quiet && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		box_left   <= b.left;
		box_top    <= b.top;
		box_width  <= b.width;
		box_height <= b.height;
		set_end    <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		v = nms_decide(b, last);
		pending_verdicts = {pending_verdicts, (typed ? typed_v : v)};
	endtask

	// threshold changes only once the block has drained
	task automatic write_threshold(input logic [8:0] thr);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= thr;
		@(posedge clk);
		cfg_we  <= 1'b0;
		iou_thr = thr;
	endtask

	// output side: check accepted words, then pick the next stall
	always @(posedge clk) begin : watch_out
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				flag_mismatch("result word with nothing pending");
			end else begin
				want = pending_verdicts.pop_front();
				if (kept !== want.keep)
					flag_mismatch($sformatf("kept %b, want %b (pos %0d)",
						kept, want.keep, want.pos));
				if (box_position !== want.pos)
					flag_mismatch($sformatf("box_position %0d, want %0d",
						box_position, want.pos));
				if (store_overflow !== want.ovf)
					flag_mismatch($sformatf("store_overflow %b, want %b (pos %0d)",
						store_overflow, want.ovf, want.pos));
				if (final_box !== want.last)
					flag_mismatch($sformatf("final_box %b, want %b (pos %0d)",
						final_box, want.last, want.pos));
			end
		end
		out_stall <= !quiet && ($urandom_range(0, 99) < 8);
	end

	initial begin : stimulus
		gbn_pkg::box_t b;
		logic [8:0]    thr;
		int            sent, set_len, n_clu, c;
		int            cxs [4];
		int            cys [4];
		int            bws [4];
		int            bhs [4];

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, run at the reset threshold of one half.
		// First set: duplicates, partial overlap, empty boxes, edge contact,
		// coordinate extremes.
		dir_row(0, 0, 160, 160, 0, 1, 1, 0, 0);
		dir_row(0, 0, 160, 160, 0, 1, 0, 1, 0);	// duplicate goes away
		dir_row(80, 0, 160, 160, 0, 0, 0, 0, 0);	// one third overlap
		dir_row(0, 0, 0, 160, 0, 1, 1, 3, 0);	// empty box is kept
		dir_row(0, 0, 0, 160, 0, 1, 1, 4, 0);	// zero union against empty box
		dir_row(240, 0, 160, 160, 0, 1, 1, 5, 0);	// touches an edge only
		dir_row(-32768, -32768, 32767, 32767, 0, 0, 0, 0, 0);
		dir_row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0);
		dir_row(-32768, -32768, 32767, 32767, 0, 1, 0, 8, 0);
		dir_row(-1, -1, 32767, 32767, 0, 0, 0, 0, 0);
		dir_row(-32768, 32767, 0, 32767, 1, 0, 0, 0, 0);
		// second set: ratio exactly at the limit stays, one step over goes
		dir_row(0, 0, 300, 100, 0, 1, 1, 0, 0);
		dir_row(100, 0, 300, 100, 0, 1, 1, 1, 0);
		dir_row(99, 0, 300, 100, 0, 1, 0, 2, 0);
		dir_row(120, 20, 40, 40, 1, 0, 0, 0, 0);	// nested small box
		// single box set, then a short set closing on a suppressed box
		dir_row(-500, -500, 32767, 0, 1, 1, 1, 0, 0);
		dir_row(5, 5, 10, 10, 0, 1, 1, 0, 0);
		dir_row(5, 5, 10, 10, 1, 1, 0, 1, 0);
		foreach (dir_rows[i])
			send_box(dir_rows[i].box, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);

		// Store full at threshold zero: a disjoint grid overruns the store,
		// an overflowed box does not shadow its twin, any overlap kills.
		write_threshold(9'd0);
		for (int k = 0; k < 72; k++) begin
			if (k < 70)
				b = make_box((k % 10) * 320, (k / 10) * 320, 160, 160);
			else if (k == 70)
				b = make_box((66 % 10) * 320, (66 / 10) * 320, 160, 160);
			else
				b = make_box(80, 80, 160, 160);
			send_box(b, k == 71, 1'b0, '0);
		end

		// Random part: whole sets of clustered boxes with some noise, one
		// threshold per phase; one phase runs with no idling at all.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: thr = 9'd0;
				1: thr = 9'd256;
				2: thr = 9'd511;
				3: thr = 9'd64;
				4: thr = gbn_pkg::THR_RESET;
				5: thr = 9'($urandom_range(1, 255));
				6: thr = 9'($urandom_range(0, 511));
				default: thr = 9'd255;
			endcase
			write_threshold(thr);
			quiet = (ph == 4);
			sent = 0;
			while (sent < 135) begin
				set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 80)
					: $urandom_range(1, 30);
				n_clu = $urandom_range(1, 4);
				for (int i = 0; i < 4; i++) begin
					cxs[i] = int'($urandom_range(0, 60000)) - 30000;
					cys[i] = int'($urandom_range(0, 60000)) - 30000;
					bws[i] = $urandom_range(16, 6000);
					bhs[i] = $urandom_range(16, 6000);
				end
				for (int k = 0; k < set_len; k++) begin
					if ($urandom_range(0, 9) == 0) begin
						b.left   = 16'($urandom());
						b.top    = 16'($urandom());
						b.width  = 15'($urandom());
						b.height = 15'($urandom());
					end else begin
						c = $urandom_range(0, n_clu - 1);
						b = cluster_box(cxs[c], cys[c], bws[c], bhs[c]);
					end
					send_box(b, k == set_len - 1, 1'b0, '0);
					sent++;
				end
			end
		end
		quiet = 1'b0;

		// drain, then give stray words time to show up
		in_valid <= 1'b0;
		for (int w = 0; w < 5000 && pending_verdicts.size() != 0; w++)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (pending_verdicts.size() != 0)
			flag_mismatch($sformatf("%0d result words never came",
				pending_verdicts.size()));
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// hard stop far beyond the slowest correct run
	initial begin
		#40000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
